// ===== design/mdef_pkg.sv =====
// ============================================================================
// Mean difference edge filter: shared package
// Types, sizes and constants used by the front part, the job queue, the back
// part and the top level.
// ============================================================================
`default_nettype none

package mdef_pkg;

    // Pixel and field sizes
    localparam int PIXEL_BITS     = 8;
    localparam int SIZE_BITS      = 11;
    localparam int THR_BITS       = 8;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_IDX_BITS   = 2;
    localparam int COORD_BITS     = 10;

    // Default frame store limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Register reset values
    localparam logic [SIZE_BITS-1:0] RST_FRAME_WIDTH    = 11'd500;
    localparam logic [SIZE_BITS-1:0] RST_FRAME_HEIGHT   = 11'd500;
    localparam logic [THR_BITS-1:0]  RST_SEED_THRESHOLD = 8'd10;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_SEED_THRESHOLD = 2'd2
    } t_cfg_idx;

    // 3x3 window: three columns of three rows, column-major, oldest column low
    localparam int WIN_ROWS   = 3;
    localparam int WIN_COLS   = 3;
    localparam int COL_BITS   = WIN_ROWS * PIXEL_BITS;
    localparam int WIN_BITS   = WIN_COLS * COL_BITS;

    // Result slots of one job, in issue order (bit positions of the job mask)
    localparam int NUM_RES        = 4;
    localparam int RES_UP_PREV    = 0;
    localparam int RES_UP_LAST    = 1;
    localparam int RES_LAST_PREV  = 2;
    localparam int RES_LAST_LAST  = 3;

    // Job word without the row and column counters: mask, row-is-one and column-is-one flags, window
    localparam int JOB_FIX_BITS = NUM_RES + 2 + WIN_BITS;

    // Mean of nine pixels: floor(sum / 9) = (sum * 3641) >> 15, exact for sum < 2^15
    localparam int SUM_BITS   = 12;
    localparam int PROD_BITS  = 24;
    localparam int MEAN_MUL   = 3641;
    localparam int MEAN_SHIFT = 15;

    // Job queue (depth is a power of two)
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = 2;
    localparam int QCNT_BITS  = 3;

    // Configuration as seen by the front and back parts
    typedef struct packed {
        logic [SIZE_BITS-1:0] frame_width;
        logic [SIZE_BITS-1:0] frame_height;
        logic [THR_BITS-1:0]  seed_threshold;
    } t_cfg;

    // Queue status toward both sides
    typedef struct packed {
        logic                 empty;
        logic [QCNT_BITS-1:0] count;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== design/mdef_ram.sv =====
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module mdef_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/mdef_queue.sv =====
// ============================================================================
// Job queue
// Short first-in first-out queue of window jobs between front and back part.
// ============================================================================
`default_nettype none

module mdef_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WIDTH-1:0]  i_data,
    input  wire logic              i_pop,
    output logic      [WIDTH-1:0]  o_data,
    output mdef_pkg::t_q_stat      o_stat
);

    logic [WIDTH-1:0]                r_mem [mdef_pkg::QDEPTH];
    logic [mdef_pkg::QPTR_BITS-1:0]  r_wp, n_wp;
    logic [mdef_pkg::QPTR_BITS-1:0]  r_rp, n_rp;
    logic [mdef_pkg::QCNT_BITS-1:0]  r_cnt, n_cnt;

    // Advance pointers and fill count
    always_comb begin
        n_wp  = i_push ? r_wp + mdef_pkg::QPTR_BITS'(1) : r_wp;
        n_rp  = i_pop  ? r_rp + mdef_pkg::QPTR_BITS'(1) : r_rp;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + mdef_pkg::QCNT_BITS'(1);
            2'b01:   n_cnt = r_cnt - mdef_pkg::QCNT_BITS'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data = r_mem[r_rp];
    assign o_stat = {(r_cnt == '0), r_cnt};

    // The back part takes a job only when one is waiting
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("job queue popped while empty");

endmodule

`default_nettype wire

// ===== design/mdef_front.sv =====
// ============================================================================
// Front part
// Accepts pixels, keeps the raster position and the two line stores, slides
// the 3x3 window and classifies which results each pixel completes.
// ============================================================================
`default_nettype none

module mdef_front #(
    parameter int MAX_WIDTH  = mdef_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mdef_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mdef_pkg::t_cfg                     i_cfg,
    input  wire logic                               i_push,
    input  wire logic [mdef_pkg::PIXEL_BITS-1:0]    i_pixel_value,
    output logic                                    o_full,
    input  wire mdef_pkg::t_q_stat                  i_q_stat,
    output logic                                    o_job_push,
    output logic [mdef_pkg::JOB_FIX_BITS+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] o_job
);

    localparam int PB  = mdef_pkg::PIXEL_BITS;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WDW = (CW + 1 > mdef_pkg::SIZE_BITS) ? CW + 1 : mdef_pkg::SIZE_BITS;
    localparam int HDW = (RW + 1 > mdef_pkg::SIZE_BITS) ? RW + 1 : mdef_pkg::SIZE_BITS;
    localparam int QW  = mdef_pkg::QCNT_BITS + 1;

    logic                          accept;
    logic [WDW-1:0]                fw_ext;
    logic [HDW-1:0]                fh_ext;
    logic [CW-1:0]                 last_col_idx;
    logic [RW-1:0]                 last_row_idx;
    logic                          last_col, last_row;

    logic [CW-1:0]                 r_col, n_col;
    logic [RW-1:0]                 r_row, n_row;

    logic                          r_s1_valid;
    logic [PB-1:0]                 r_s1_pix;
    logic [CW-1:0]                 r_s1_col;
    logic [RW-1:0]                 r_s1_row;
    logic                          r_s1_last_col, r_s1_last_row;

    logic [2*PB-1:0]               ram_rdata;
    logic [PB-1:0]                 older_pix, newer_pix;
    logic [mdef_pkg::WIN_BITS-1:0] r_win, n_win;
    logic [mdef_pkg::NUM_RES-1:0]  mask;
    logic                          row_is1, col_is1;

    // Saturate frame sizes to 2 .. maximum and form the last indexes
    always_comb begin
        fw_ext = WDW'(i_cfg.frame_width);
        fh_ext = HDW'(i_cfg.frame_height);
        if (fw_ext < WDW'(2)) begin
            last_col_idx = CW'(1);
        end else if (fw_ext > WDW'(MAX_WIDTH)) begin
            last_col_idx = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = CW'(fw_ext - WDW'(1));
        end
        if (fh_ext < HDW'(2)) begin
            last_row_idx = RW'(1);
        end else if (fh_ext > HDW'(MAX_HEIGHT)) begin
            last_row_idx = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row_idx = RW'(fh_ext - HDW'(1));
        end
        last_col = (r_col >= last_col_idx);
        last_row = (r_row >= last_row_idx);
    end

    // Hold off input while the queue could not take the word in flight
    assign o_full = (QW'(i_q_stat.count) + QW'(r_s1_valid)) >= QW'(mdef_pkg::QDEPTH);
    assign accept = i_push && !o_full;

    // Advance the raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
        end
    end

    // Capture the accepted word while the line stores are read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_pixel_value;
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
        end
    end

    // Both line stores in one RAM: older row high, newer row low
    mdef_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata ({newer_pix, r_s1_pix}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign older_pix = ram_rdata[2*PB-1:PB];
    assign newer_pix = ram_rdata[PB-1:0];

    // Slide the window by one column and load the new column
    assign n_win = {r_s1_pix, newer_pix, older_pix,
                    r_win[mdef_pkg::WIN_BITS-1:mdef_pkg::COL_BITS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // Classify which centres this word completes
    always_comb begin
        mask = '0;
        mask[mdef_pkg::RES_UP_PREV]   = (r_s1_row != '0) && (r_s1_col != '0);
        mask[mdef_pkg::RES_UP_LAST]   = (r_s1_row != '0) && r_s1_last_col;
        mask[mdef_pkg::RES_LAST_PREV] = r_s1_last_row && (r_s1_col != '0);
        mask[mdef_pkg::RES_LAST_LAST] = r_s1_last_row && r_s1_last_col;
        row_is1 = (r_s1_row == RW'(1));
        col_is1 = (r_s1_col == CW'(1));
    end

    assign o_job_push = r_s1_valid && (mask != '0);
    assign o_job      = {mask, row_is1, col_is1, r_s1_row, r_s1_col, n_win};

    // The full logic must leave room for every job that is pushed
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> (i_q_stat.count < mdef_pkg::QCNT_BITS'(mdef_pkg::QDEPTH)))
        else $error("job pushed into a full queue");

endmodule

`default_nettype wire

// ===== design/mdef_back.sv =====
// ============================================================================
// Back part
// Expands each queued job into its results, one per cycle unless stalled:
// clamped 3x3 sum, mean by reciprocal multiply, absolute difference, seed compare.
// ============================================================================
`default_nettype none

module mdef_back #(
    parameter int MAX_WIDTH  = mdef_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mdef_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mdef_pkg::t_cfg                     i_cfg,
    input  wire mdef_pkg::t_q_stat                  i_q_stat,
    input  wire logic [mdef_pkg::JOB_FIX_BITS+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] i_job,
    output logic                                    o_job_pop,
    output logic                                    o_empty,
    input  wire logic                               i_pop,
    output logic [mdef_pkg::COORD_BITS-1:0]         o_center_row,
    output logic [mdef_pkg::COORD_BITS-1:0]         o_center_col,
    output logic [mdef_pkg::PIXEL_BITS-1:0]         o_edge_value,
    output logic                                    o_is_seed,
    output logic                                    o_frame_done
);

    localparam int PB = mdef_pkg::PIXEL_BITS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int NR = mdef_pkg::NUM_RES;
    localparam int WB = mdef_pkg::WIN_BITS;
    localparam int SB = mdef_pkg::SUM_BITS;
    localparam int XB = mdef_pkg::COORD_BITS;

    // Pixel of the window at a column slot and row slot
    function automatic logic [PB-1:0] win_pix(input logic [WB-1:0] win,
                                              input logic [1:0] col,
                                              input logic [1:0] row);
        logic [3:0] slot;
        slot = 4'(col) * 4'd3 + 4'(row);
        return win[slot * PB +: PB];
    endfunction

    logic [WB-1:0]     j_win;
    logic [CW-1:0]     j_col;
    logic [RW-1:0]     j_row;
    logic              j_col_is1, j_row_is1;
    logic [NR-1:0]     j_mask;

    logic              adv, issue, last_pick;
    logic [NR-1:0]     left, pick;
    logic [NR-1:0]     r_done, n_done;
    logic              row_last, col_last;
    logic [1:0]        ridx [3];
    logic [1:0]        cidx [3];
    logic [SB-1:0]     sum;
    logic [PB-1:0]     ctr;
    logic [RW-1:0]     res_row;
    logic [CW-1:0]     res_col;

    logic              r_b1_valid;
    logic [SB-1:0]     r_b1_sum;
    logic [PB-1:0]     r_b1_ctr;
    logic [XB-1:0]     r_b1_row, r_b1_col;
    logic              r_b1_done;

    logic [mdef_pkg::PROD_BITS-1:0] prod;
    logic              r_b2_valid;
    logic [PB-1:0]     r_b2_mean;
    logic [PB-1:0]     r_b2_ctr;
    logic [XB-1:0]     r_b2_row, r_b2_col;
    logic              r_b2_done;

    logic [PB-1:0]     diff;
    logic              r_o_valid;
    logic [PB-1:0]     r_o_edge;
    logic              r_o_seed;
    logic [XB-1:0]     r_o_row, r_o_col;
    logic              r_o_done;

    // Unpack the job at the queue head
    assign j_win     = i_job[WB-1:0];
    assign j_col     = i_job[WB +: CW];
    assign j_row     = i_job[WB + CW +: RW];
    assign j_col_is1 = i_job[WB + CW + RW];
    assign j_row_is1 = i_job[WB + CW + RW + 1];
    assign j_mask    = i_job[WB + CW + RW + 2 +: NR];

    // Pick the next result of the head job; drop the job after its last one
    assign adv       = !r_o_valid || i_pop;
    assign left      = i_q_stat.empty ? '0 : (j_mask & ~r_done);
    assign pick      = left & (~left + NR'(1));
    assign issue     = adv && (left != '0);
    assign last_pick = ((left & ~pick) == '0);
    assign o_job_pop = issue && last_pick;

    always_comb begin
        n_done = r_done;
        if (issue) begin
            n_done = last_pick ? '0 : (r_done | pick);
        end
    end

    // Clamp rows and columns to the frame edge and sum the neighborhood
    always_comb begin
        row_last = pick[mdef_pkg::RES_LAST_PREV] | pick[mdef_pkg::RES_LAST_LAST];
        col_last = pick[mdef_pkg::RES_UP_LAST]   | pick[mdef_pkg::RES_LAST_LAST];
        ridx[0]  = (row_last || j_row_is1) ? 2'd1 : 2'd0;
        ridx[1]  = row_last ? 2'd2 : 2'd1;
        ridx[2]  = 2'd2;
        cidx[0]  = (col_last || j_col_is1) ? 2'd1 : 2'd0;
        cidx[1]  = col_last ? 2'd2 : 2'd1;
        cidx[2]  = 2'd2;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sum = sum + SB'(win_pix(j_win, cidx[i], ridx[j]));
            end
        end
        ctr     = win_pix(j_win, cidx[1], ridx[1]);
        res_row = row_last ? j_row : j_row - RW'(1);
        res_col = col_last ? j_col : j_col - CW'(1);
    end

    // Mean by reciprocal multiply, then absolute difference
    assign prod = mdef_pkg::PROD_BITS'(r_b1_sum) *
                  mdef_pkg::PROD_BITS'(mdef_pkg::MEAN_MUL);
    assign diff = (r_b2_mean > r_b2_ctr) ? r_b2_mean - r_b2_ctr : r_b2_ctr - r_b2_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= '0;
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_done <= n_done;
            if (adv) begin
                r_b1_valid <= issue;
                r_b2_valid <= r_b1_valid;
                r_o_valid  <= r_b2_valid;
            end
        end
    end

    // Advance the result stages together; hold while the output word waits
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_sum  <= sum;
            r_b1_ctr  <= ctr;
            r_b1_row  <= XB'(res_row);
            r_b1_col  <= XB'(res_col);
            r_b1_done <= pick[mdef_pkg::RES_LAST_LAST];

            r_b2_mean <= prod[mdef_pkg::MEAN_SHIFT +: PB];
            r_b2_ctr  <= r_b1_ctr;
            r_b2_row  <= r_b1_row;
            r_b2_col  <= r_b1_col;
            r_b2_done <= r_b1_done;

            r_o_edge  <= diff;
            r_o_seed  <= (diff > i_cfg.seed_threshold);
            r_o_row   <= r_b2_row;
            r_o_col   <= r_b2_col;
            r_o_done  <= r_b2_done;
        end
    end

    assign o_empty      = !r_o_valid;
    assign o_center_row = r_o_row;
    assign o_center_col = r_o_col;
    assign o_edge_value = r_o_edge;
    assign o_is_seed    = r_o_seed;
    assign o_frame_done = r_o_done;

    // Partly issued jobs stay at the queue head
    a_done_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != '0) |-> !i_q_stat.empty)
        else $error("issued results recorded without a job at the head");

    // Only results the job asked for are marked as issued
    a_done_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_stat.empty |-> ((r_done & ~j_mask) == '0))
        else $error("issued result outside the job mask");

endmodule

`default_nettype wire

// ===== design/mean_difference_edge_filter.sv =====
// Path: a pixel that completes a centre passes the input stage, the job queue
//   and the b1, b2 and output stages of the back part before its result shows.
// Throughput: one pixel per cycle unless full; results leave at one per cycle unless pop holds them,
//   so on the last column and the last row, where a pixel completes 2 or 4 centres, the
//   back part's single result pipeline sets the pace through a 4-entry queue.
// Reset: synchronous; clears position, window, queue and pipeline; line store
//   contents stay as they are and are rewritten by the first rows of a frame.
// ============================================================================
// Mean difference edge filter: top level
// Configuration registers, front part, job queue and back part.
// ============================================================================
`default_nettype none

module mean_difference_edge_filter #(
    parameter int MAX_WIDTH  = mdef_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mdef_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mdef_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [mdef_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [mdef_pkg::PIXEL_BITS-1:0]     i_pixel_value,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [mdef_pkg::COORD_BITS-1:0]          o_center_row,
    output logic [mdef_pkg::COORD_BITS-1:0]          o_center_col,
    output logic [mdef_pkg::PIXEL_BITS-1:0]          o_edge_value,
    output logic                                     o_is_seed,
    output logic                                     o_frame_done
);

    localparam int JOB_BITS = mdef_pkg::JOB_FIX_BITS + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH);

    mdef_pkg::t_cfg    r_cfg, n_cfg;
    mdef_pkg::t_q_stat q_stat;
    logic              job_push, job_pop;
    logic [JOB_BITS-1:0] job_in, job_out;

    // Write configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                mdef_pkg::CFG_FRAME_WIDTH:    n_cfg.frame_width    = i_cfg_data;
                mdef_pkg::CFG_FRAME_HEIGHT:   n_cfg.frame_height   = i_cfg_data;
                mdef_pkg::CFG_SEED_THRESHOLD:
                    n_cfg.seed_threshold = i_cfg_data[mdef_pkg::THR_BITS-1:0];
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= mdef_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height   <= mdef_pkg::RST_FRAME_HEIGHT;
            r_cfg.seed_threshold <= mdef_pkg::RST_SEED_THRESHOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mdef_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .i_pixel_value (i_pixel_value),
        .o_full        (full),
        .i_q_stat      (q_stat),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    mdef_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_stat  (q_stat)
    );

    mdef_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_stat     (q_stat),
        .i_job        (job_out),
        .o_job_pop    (job_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_center_row (o_center_row),
        .o_center_col (o_center_col),
        .o_edge_value (o_edge_value),
        .o_is_seed    (o_is_seed),
        .o_frame_done (o_frame_done)
    );

endmodule

`default_nettype wire
